// ===== design/h2r_pkg.sv =====
// ----------------------------------------------------------------------------
// h2r_pkg
// Shared types and constants of the HSL to RGB converter pipeline.
// ----------------------------------------------------------------------------
package h2r_pkg;

  // Pipeline depth and stage positions in the stage enable vector
  localparam int NUM_STAGES  = 6;
  localparam int ST_PREP     = 0;  // clamp inputs, form hue offsets
  localparam int ST_MUL_LS   = 1;  // lightness times saturation, ramp slope
  localparam int ST_PQ       = 2;  // q, p and q - p
  localparam int ST_MUL_RAMP = 3;  // ramp product
  localparam int ST_CHAN     = 4;  // channel select
  localparam int ST_BYTE     = 5;  // scale by 255, clamp

  // Stream word widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  typedef logic [NUM_STAGES-1:0] stage_en_t;

  // Segment of the piecewise hue ramp
  typedef enum logic [1:0] {
    RGN_RISE,
    RGN_FLAT_HI,
    RGN_FALL,
    RGN_FLAT_LO
  } region_t;

endpackage

// ===== design/hsl_to_rgb_converter_core.sv =====
// Path: an accepted word passes stages ST_PREP, ST_MUL_LS, ST_PQ, ST_MUL_RAMP,
// ST_CHAN and ST_BYTE in that order, each a register, to the output.
// Throughput: one word per cycle while out_tready stays high, each stage alike.
// A stall holds only full stages up to the output; stages behind a gap move on.
// Reset (rst_n low, synchronous) clears all stage valid bits; data regs keep.
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter_core
// HSL to RGB color conversion, fixed point, six-stage pipeline with a valid
// bit per stage and per-stage ready so a downstream stall drops nothing.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter_core #(
  parameter int FRAC_BITS = 16   // internal fraction bits, 8..24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // in_tdata: hue [15:0], saturation [24:16], lightness [33:25], zero [39:34]
  input  logic [h2r_pkg::IN_TDATA_W-1:0]      in_tdata,
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_tdata: red [7:0], green [15:8], blue [23:16]
  output logic [h2r_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import h2r_pkg::*;

  logic [NUM_STAGES-1:0] valid_r, valid_nxt;
  logic [NUM_STAGES:0]   ready;
  stage_en_t             en;

  logic [FRAC_BITS:0]    s0, l0;
  logic [FRAC_BITS-1:0]  t_red, t_green, t_blue;
  logic [FRAC_BITS:0]    d2, p3, q3, l3;
  logic                  grey3;
  logic [7:0]            red, green, blue;

  // Stage k takes a new word when it is empty or its word moves on this cycle
  always_comb begin
    ready[NUM_STAGES] = out_tready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      ready[k] = !valid_r[k] || ready[k+1];
    end
  end

  assign en = ready[NUM_STAGES-1:0];

  // Advance valid bits with the data; hold them where the stage stalls
  always_comb begin
    valid_nxt[0] = ready[0] ? in_tvalid : valid_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      valid_nxt[k] = ready[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_tready  = ready[0];
  assign out_tvalid = valid_r[NUM_STAGES-1];
  assign out_tdata  = {blue, green, red};

  // Clamp and scale inputs, form the hue position of each channel
  h2r_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk        (clk),
    .en         (en),
    .hue        (in_tdata[15:0]),
    .saturation (in_tdata[24:16]),
    .lightness  (in_tdata[33:25]),
    .s_o        (s0),
    .l_o        (l0),
    .t_red_o    (t_red),
    .t_green_o  (t_green),
    .t_blue_o   (t_blue)
  );

  // Shared q and p for all three channels
  h2r_pq #(.FRAC_BITS(FRAC_BITS)) u_pq (
    .clk    (clk),
    .en     (en),
    .s_i    (s0),
    .l_i    (l0),
    .d_o    (d2),
    .p_o    (p3),
    .q_o    (q3),
    .l_o    (l3),
    .grey_o (grey3)
  );

  // One ramp and byte scaler per channel
  h2r_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp_red (
    .clk    (clk),
    .en     (en),
    .t_i    (t_red),
    .d_i    (d2),
    .p_i    (p3),
    .q_i    (q3),
    .l_i    (l3),
    .grey_i (grey3),
    .byte_o (red)
  );

  h2r_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp_green (
    .clk    (clk),
    .en     (en),
    .t_i    (t_green),
    .d_i    (d2),
    .p_i    (p3),
    .q_i    (q3),
    .l_i    (l3),
    .grey_i (grey3),
    .byte_o (green)
  );

  h2r_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp_blue (
    .clk    (clk),
    .en     (en),
    .t_i    (t_blue),
    .d_i    (d2),
    .p_i    (p3),
    .q_i    (q3),
    .l_i    (l3),
    .grey_i (grey3),
    .byte_o (blue)
  );

endmodule

// ===== design/h2r_prep.sv =====
// ----------------------------------------------------------------------------
// h2r_prep
// Input stage: clamp saturation and lightness, scale to fixed point and form
// the three hue positions of the channels.
// ----------------------------------------------------------------------------
module h2r_prep #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  h2r_pkg::stage_en_t    en,
  input  logic [15:0]           hue,
  input  logic [8:0]            saturation,
  input  logic [8:0]            lightness,
  output logic [FRAC_BITS:0]    s_o,
  output logic [FRAC_BITS:0]    l_o,
  output logic [FRAC_BITS-1:0]  t_red_o,
  output logic [FRAC_BITS-1:0]  t_green_o,
  output logic [FRAC_BITS-1:0]  t_blue_o
);
  import h2r_pkg::*;

  localparam int W  = FRAC_BITS + 1;
  localparam int HW = FRAC_BITS + 16;
  localparam logic [FRAC_BITS-1:0] THIRD = FRAC_BITS'(((1 << FRAC_BITS) + 1) / 3);

  logic [8:0]           sat_c;
  logic [8:0]           light_c;
  logic [HW-1:0]        hue_x;
  logic [FRAC_BITS-1:0] h;
  logic [W-1:0]         s_r, l_r;
  logic [FRAC_BITS-1:0] t_red_r, t_green_r, t_blue_r;

  always_comb begin
    sat_c   = (saturation > 9'd256) ? 9'd256 : saturation;
    light_c = (lightness > 9'd256) ? 9'd256 : lightness;
    hue_x   = HW'(hue) << FRAC_BITS;
    h       = hue_x[HW-1:16];
  end

  always_ff @(posedge clk) begin
    if (en[ST_PREP]) begin
      s_r       <= W'(sat_c) << (FRAC_BITS - 8);
      l_r       <= W'(light_c) << (FRAC_BITS - 8);
      t_red_r   <= h + THIRD;   // wraps modulo one turn
      t_green_r <= h;
      t_blue_r  <= h - THIRD;
    end
  end

  assign s_o       = s_r;
  assign l_o       = l_r;
  assign t_red_o   = t_red_r;
  assign t_green_o = t_green_r;
  assign t_blue_o  = t_blue_r;

endmodule

// ===== design/h2r_pq.sv =====
// ----------------------------------------------------------------------------
// h2r_pq
// Form q, p and their difference from lightness and saturation; hold them
// in step with the per-channel ramp stages.
// ----------------------------------------------------------------------------
module h2r_pq #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  h2r_pkg::stage_en_t en,
  input  logic [FRAC_BITS:0] s_i,
  input  logic [FRAC_BITS:0] l_i,
  output logic [FRAC_BITS:0] d_o,     // q - p, stage ST_PQ
  output logic [FRAC_BITS:0] p_o,     // stage ST_MUL_RAMP
  output logic [FRAC_BITS:0] q_o,
  output logic [FRAC_BITS:0] l_o,
  output logic               grey_o
);
  import h2r_pkg::*;

  localparam int W  = FRAC_BITS + 1;
  localparam int PW = 2 * W;
  localparam logic [W-1:0] HALF = W'(1) << (FRAC_BITS - 1);

  logic [PW-1:0] ls_prod_r;
  logic [W-1:0]  l1_r, s1_r;
  logic          grey1_r;

  logic [W-1:0]  ls, a, q_c, p_c, d_c;
  logic          ge;

  logic [W-1:0]  p2_r, q2_r, d2_r, l2_r;
  logic          grey2_r;
  logic [W-1:0]  p3_r, q3_r, l3_r;
  logic          grey3_r;

  always_ff @(posedge clk) begin
    if (en[ST_MUL_LS]) begin
      ls_prod_r <= PW'(l_i) * PW'(s_i);
      l1_r      <= l_i;
      s1_r      <= s_i;
      grey1_r   <= (s_i == '0);
    end
  end

  // q = l + a, p = l - a, q - p = 2a, with a = l*s below half, s - l*s above
  always_comb begin
    ls  = W'(ls_prod_r >> FRAC_BITS);
    a   = (l1_r < HALF) ? ls : (s1_r - ls);
    q_c = l1_r + a;
    ge  = (l1_r >= a);
    p_c = ge ? (l1_r - a) : '0;
    d_c = ge ? W'({a, 1'b0}) : q_c;
  end

  always_ff @(posedge clk) begin
    if (en[ST_PQ]) begin
      p2_r    <= p_c;
      q2_r    <= q_c;
      d2_r    <= d_c;
      l2_r    <= l1_r;
      grey2_r <= grey1_r;
    end
    if (en[ST_MUL_RAMP]) begin
      p3_r    <= p2_r;
      q3_r    <= q2_r;
      l3_r    <= l2_r;
      grey3_r <= grey2_r;
    end
  end

  assign d_o    = d2_r;
  assign p_o    = p3_r;
  assign q_o    = q3_r;
  assign l_o    = l3_r;
  assign grey_o = grey3_r;

endmodule

// ===== design/h2r_ramp.sv =====
// ----------------------------------------------------------------------------
// h2r_ramp
// One color channel: evaluate the piecewise hue ramp at the channel's hue
// position, then scale by 255 and clamp to a byte.
// ----------------------------------------------------------------------------
module h2r_ramp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  h2r_pkg::stage_en_t   en,
  input  logic [FRAC_BITS-1:0] t_i,
  input  logic [FRAC_BITS:0]   d_i,
  input  logic [FRAC_BITS:0]   p_i,
  input  logic [FRAC_BITS:0]   q_i,
  input  logic [FRAC_BITS:0]   l_i,
  input  logic                 grey_i,
  output logic [7:0]           byte_o
);
  import h2r_pkg::*;

  localparam int W  = FRAC_BITS + 1;
  localparam int MW = FRAC_BITS + 3;
  localparam int RW = W + MW;
  localparam int CW = FRAC_BITS + 5;
  localparam int SW = CW + 8;
  localparam logic [FRAC_BITS-1:0] SIXTH = FRAC_BITS'(((1 << FRAC_BITS) + 3) / 6);
  localparam logic [FRAC_BITS-1:0] HALF  = FRAC_BITS'((1 << FRAC_BITS) / 2);
  localparam logic [FRAC_BITS-1:0] TWO_THIRDS =
    FRAC_BITS'((2 * (1 << FRAC_BITS) + 1) / 3);

  region_t              rgn_c;
  logic [MW-1:0]        m_c;
  logic [MW-1:0]        span;

  region_t              rgn1_r, rgn2_r, rgn3_r;
  logic [MW-1:0]        m1_r, m2_r;
  logic [RW-1:0]        prod3_r;
  logic [CW-1:0]        c_c, c4_r;
  logic [SW-1:0]        scaled, v;
  logic [7:0]           byte5_r;

  // Pick the ramp segment and its slope factor: 6t rising, 6(2/3 - t) falling
  always_comb begin
    m_c  = '0;
    span = '0;
    if (t_i < SIXTH) begin
      rgn_c = RGN_RISE;
      span  = MW'(t_i);
    end else if (t_i < HALF) begin
      rgn_c = RGN_FLAT_HI;
    end else if (t_i < TWO_THIRDS) begin
      rgn_c = RGN_FALL;
      span  = MW'(TWO_THIRDS - t_i);
    end else begin
      rgn_c = RGN_FLAT_LO;
    end
    m_c = (span << 2) + (span << 1);
  end

  always_comb begin
    if (grey_i) begin
      c_c = CW'(l_i);
    end else begin
      case (rgn3_r)
        RGN_RISE, RGN_FALL: c_c = CW'(p_i) + CW'(prod3_r >> FRAC_BITS);
        RGN_FLAT_HI:        c_c = CW'(q_i);
        RGN_FLAT_LO:        c_c = CW'(p_i);
        default:            c_c = CW'(p_i);
      endcase
    end
  end

  always_comb begin
    scaled = (SW'(c4_r) << 8) - SW'(c4_r);
    v      = scaled >> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (en[ST_MUL_LS]) begin
      rgn1_r <= rgn_c;
      m1_r   <= m_c;
    end
    if (en[ST_PQ]) begin
      rgn2_r <= rgn1_r;
      m2_r   <= m1_r;
    end
    if (en[ST_MUL_RAMP]) begin
      rgn3_r  <= rgn2_r;
      prod3_r <= RW'(d_i) * RW'(m2_r);
    end
    if (en[ST_CHAN]) begin
      c4_r <= c_c;
    end
    if (en[ST_BYTE]) begin
      byte5_r <= (v > SW'(255)) ? 8'hFF : v[7:0];
    end
  end

  assign byte_o = byte5_r;

endmodule
